// ===== rtl/qtrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtrs_pkg: shared types and constants of the TRS matrix core
// Widths of the doubled quaternion products and rotation terms, the queued
// item layout, row codes and the fixed-point constants 1.0.
// ----------------------------------------------------------------------------
package qtrs_pkg;

  localparam int DATA_W = 32;
  // 2*a*b of two Q2.30 values floored to Q.30 reaches 2^33.
  localparam int PROD_W = 35;
  // Sums of two products and 1.0 stay below 2^35 in magnitude.
  localparam int TERM_W = 36;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [TERM_W-1:0] ONE_Q30 = 36'sd1073741824;
  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [DATA_W-1:0] ZERO_Q16 = 32'sd0;

  localparam logic [1:0] ROW_0 = 2'd0;
  localparam logic [1:0] ROW_1 = 2'd1;
  localparam logic [1:0] ROW_2 = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  // One classified transform: the nine doubled products plus scale and position.
  typedef struct packed {
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] wx;
    logic signed [PROD_W-1:0] wy;
    logic signed [PROD_W-1:0] wz;
    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;
    logic signed [DATA_W-1:0] sz;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] pz;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/qtrs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtrs_front: input stage of the TRS matrix core
// Registers one transform beat and forms the nine doubled quaternion
// products, which are pushed into the item queue.
// ----------------------------------------------------------------------------
module qtrs_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  signed [31:0]    in_quat_x,
  input  wire  signed [31:0]    in_quat_y,
  input  wire  signed [31:0]    in_quat_z,
  input  wire  signed [31:0]    in_quat_w,
  input  wire  signed [31:0]    in_scale_x,
  input  wire  signed [31:0]    in_scale_y,
  input  wire  signed [31:0]    in_scale_z,
  input  wire  signed [31:0]    in_pos_x,
  input  wire  signed [31:0]    in_pos_y,
  input  wire  signed [31:0]    in_pos_z,
  input  wire qtrs_pkg::q_stat_t q_stat,
  output logic                  push,
  output qtrs_pkg::item_t       push_data
);

  logic                     valid_r;
  logic signed [31:0]       qx_r, qy_r, qz_r, qw_r;
  logic signed [31:0]       sx_r, sy_r, sz_r, px_r, py_r, pz_r;
  logic                     accept;

  // Floor of a*b / 2^29, i.e. 2*a*b in Q.30.
  function automatic logic signed [qtrs_pkg::PROD_W-1:0] dprod(
    input logic signed [31:0] a,
    input logic signed [31:0] b
  );
    logic signed [63:0] p;
    p = a * b;
    return p[63:29];
  endfunction

  assign in_stall = valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = valid_r && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qx_r <= in_quat_x;
      qy_r <= in_quat_y;
      qz_r <= in_quat_z;
      qw_r <= in_quat_w;
      sx_r <= in_scale_x;
      sy_r <= in_scale_y;
      sz_r <= in_scale_z;
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      pz_r <= in_pos_z;
    end
  end

  always_comb begin
    push_data.xx = dprod(qx_r, qx_r);
    push_data.xy = dprod(qx_r, qy_r);
    push_data.xz = dprod(qx_r, qz_r);
    push_data.yy = dprod(qy_r, qy_r);
    push_data.yz = dprod(qy_r, qz_r);
    push_data.zz = dprod(qz_r, qz_r);
    push_data.wx = dprod(qw_r, qx_r);
    push_data.wy = dprod(qw_r, qy_r);
    push_data.wz = dprod(qw_r, qz_r);
    push_data.sx = sx_r;
    push_data.sy = sy_r;
    push_data.sz = sz_r;
    push_data.px = px_r;
    push_data.py = py_r;
    push_data.pz = pz_r;
  end

endmodule
`default_nettype wire

// ===== rtl/qtrs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtrs_queue: item queue between front and back
// A small register queue of classified transforms. The head entry is read
// directly by the back end and removed when its last row is issued.
// ----------------------------------------------------------------------------
module qtrs_queue #(
  parameter int DEPTH = qtrs_pkg::QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wire qtrs_pkg::item_t push_data,
  input  wire                pop,
  output qtrs_pkg::item_t    head,
  output qtrs_pkg::q_stat_t  q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  qtrs_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CNT_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CNT_FULL)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("queue count did not follow a lone write");

endmodule
`default_nettype wire

// ===== rtl/qtrs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtrs_back: row sequencer and scaling pipeline
// Issues the four rows of the head transform one per cycle while the output
// is not stalled, forms the rotation terms, scales the rotation columns with
// round-to-nearest and saturation, and holds the row beat in the output register.
// ----------------------------------------------------------------------------
module qtrs_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire qtrs_pkg::item_t head,
  input  wire qtrs_pkg::q_stat_t q_stat,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [1:0]          out_row_index,
  output logic signed [31:0]  out_col_0,
  output logic signed [31:0]  out_col_1,
  output logic signed [31:0]  out_col_2,
  output logic signed [31:0]  out_col_3,
  output logic                out_last_row
);

  localparam int TW = qtrs_pkg::TERM_W;
  localparam int QW = TW + 4;
  localparam int LANES = 3;

  logic                   advance, issue;
  logic [1:0]             row_r;

  logic signed [TW-1:0]   e_xx, e_xy, e_xz, e_yy, e_yz, e_zz, e_wx, e_wy, e_wz;
  logic signed [TW-1:0]   term_d [LANES];
  logic signed [31:0]     col3_d;

  logic                   a_valid_r;
  logic [1:0]             a_row_r;
  logic signed [TW-1:0]   a_term_r [LANES];
  logic signed [31:0]     a_scale_r [LANES];
  logic signed [31:0]     a_col3_r;

  logic                   b_valid_r;
  logic [1:0]             b_row_r;
  logic [TW-1:0]          b_mt_r [LANES];
  logic [31:0]            b_ms_r [LANES];
  logic                   b_neg_r [LANES];
  logic signed [31:0]     b_col3_r;

  logic                   c_valid_r;
  logic [1:0]             c_row_r;
  logic [63:0]            c_low_r [LANES];
  logic [TW-1:0]          c_hm_r [LANES];
  logic                   c_neg_r [LANES];
  logic signed [31:0]     c_col3_r;

  logic [QW-1:0]          q_d [LANES];
  logic signed [31:0]     col_d [LANES];

  logic                   out_valid_r;
  logic [1:0]             out_row_r;
  logic signed [31:0]     out_col_r [LANES];
  logic signed [31:0]     out_col3_r;

  // The whole pipeline moves together whenever the output register can take a beat.
  assign advance = !out_valid_r || !out_stall;
  assign issue   = advance && !q_stat.empty;
  assign pop     = issue && (row_r == qtrs_pkg::ROW_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= qtrs_pkg::ROW_0;
    end else if (issue) begin
      row_r <= row_r + 1'b1;
    end
  end

  assign e_xx = TW'(head.xx);
  assign e_xy = TW'(head.xy);
  assign e_xz = TW'(head.xz);
  assign e_yy = TW'(head.yy);
  assign e_yz = TW'(head.yz);
  assign e_zz = TW'(head.zz);
  assign e_wx = TW'(head.wx);
  assign e_wy = TW'(head.wy);
  assign e_wz = TW'(head.wz);

  always_comb begin
    term_d[0] = '0;
    term_d[1] = '0;
    term_d[2] = '0;
    col3_d    = qtrs_pkg::ONE_Q16;
    unique case (row_r)
      qtrs_pkg::ROW_0: begin
        term_d[0] = qtrs_pkg::ONE_Q30 - (e_yy + e_zz);
        term_d[1] = e_xy - e_wz;
        term_d[2] = e_xz + e_wy;
        col3_d    = head.px;
      end
      qtrs_pkg::ROW_1: begin
        term_d[0] = e_xy + e_wz;
        term_d[1] = qtrs_pkg::ONE_Q30 - (e_xx + e_zz);
        term_d[2] = e_yz - e_wx;
        col3_d    = head.py;
      end
      qtrs_pkg::ROW_2: begin
        term_d[0] = e_xz - e_wy;
        term_d[1] = e_yz + e_wx;
        term_d[2] = qtrs_pkg::ONE_Q30 - (e_xx + e_yy);
        col3_d    = head.pz;
      end
      qtrs_pkg::ROW_LAST: begin
        // Zero terms give zero columns; the fourth column carries 1.0.
        col3_d = qtrs_pkg::ONE_Q16;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r   <= !q_stat.empty;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_row_r      <= row_r;
      a_col3_r     <= col3_d;
      a_scale_r[0] <= head.sx;
      a_scale_r[1] <= head.sy;
      a_scale_r[2] <= head.sz;
      b_row_r      <= a_row_r;
      b_col3_r     <= a_col3_r;
      c_row_r      <= b_row_r;
      c_col3_r     <= b_col3_r;
      out_row_r    <= c_row_r;
      out_col3_r   <= c_col3_r;
      for (int i = 0; i < LANES; i++) begin
        a_term_r[i]  <= term_d[i];
        b_mt_r[i]    <= a_term_r[i][TW-1] ? TW'(-a_term_r[i]) : TW'(a_term_r[i]);
        b_ms_r[i]    <= a_scale_r[i][31] ? 32'd0 - $unsigned(a_scale_r[i])
                                         : $unsigned(a_scale_r[i]);
        b_neg_r[i]   <= a_term_r[i][TW-1] ^ a_scale_r[i][31];
        c_low_r[i]   <= 64'(b_mt_r[i][31:0]) * 64'(b_ms_r[i]);
        c_hm_r[i]    <= TW'(b_mt_r[i][TW-1:32]) * TW'(b_ms_r[i]);
        c_neg_r[i]   <= b_neg_r[i];
        out_col_r[i] <= col_d[i];
      end
    end
  end

  // Magnitude product over 2^30 rounded half away from zero, then signed saturation.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      q_d[i] = QW'({c_hm_r[i], 2'b00}) + QW'(c_low_r[i][63:30]) + QW'(c_low_r[i][29]);
      if (c_neg_r[i]) begin
        if (q_d[i] >= QW'(33'h0_8000_0000)) begin
          col_d[i] = 32'sh8000_0000;
        end else begin
          col_d[i] = 32'd0 - q_d[i][31:0];
        end
      end else if (q_d[i] > QW'(32'h7FFF_FFFF)) begin
        col_d[i] = 32'sh7FFF_FFFF;
      end else begin
        col_d[i] = q_d[i][31:0];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_col_0     = out_col_r[0];
  assign out_col_1     = out_col_r[1];
  assign out_col_2     = out_col_r[2];
  assign out_col_3     = out_col3_r;
  assign out_last_row  = (out_row_r == qtrs_pkg::ROW_LAST);

  a_last_row_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_row_r == qtrs_pkg::ROW_LAST) |->
      (out_col_r[0] == qtrs_pkg::ZERO_Q16 && out_col_r[1] == qtrs_pkg::ZERO_Q16 &&
       out_col_r[2] == qtrs_pkg::ZERO_Q16 && out_col3_r == qtrs_pkg::ONE_Q16))
    else $error("fourth row is not 0, 0, 0, 1.0");

  a_row_carried: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && advance) |=> (b_valid_r && b_row_r == $past(a_row_r)))
    else $error("row number lost between pipeline stages");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && row_r != qtrs_pkg::ROW_LAST) |=> !q_stat.empty)
    else $error("transform left the queue before its last row");

endmodule
`default_nettype wire

// ===== rtl/quaternion_trs_matrix_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_trs_matrix_core: quaternion to translate-rotate-scale matrix
// Turns one transform beat into the four row beats of its 4x4 matrix.
// ----------------------------------------------------------------------------
// A transform beat (Q2.30 quaternion, Q16.16 scale and position) produces four
// row beats, rows 0 to 3 in order, with out_last_row marking row 3, which is
// always 0, 0, 0, 1.0. The row sequencer issues one row per cycle, while the
// output is not stalled and the queue is not empty, through three column lanes,
// each with a 32x32 and a 4x32 multiplier. Row 0 of a transform passes the input
// register, the queue entry, stages a, b and c and the output register. Up to
// QUEUE_DEPTH transforms wait between the input stage and the row sequencer, so
// input and output stall independently.
module quaternion_trs_matrix_core #(
  parameter int QUEUE_DEPTH = qtrs_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  signed [31:0]  in_quat_x,
  input  wire  signed [31:0]  in_quat_y,
  input  wire  signed [31:0]  in_quat_z,
  input  wire  signed [31:0]  in_quat_w,
  input  wire  signed [31:0]  in_scale_x,
  input  wire  signed [31:0]  in_scale_y,
  input  wire  signed [31:0]  in_scale_z,
  input  wire  signed [31:0]  in_pos_x,
  input  wire  signed [31:0]  in_pos_y,
  input  wire  signed [31:0]  in_pos_z,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [1:0]          out_row_index,
  output logic signed [31:0]  out_col_0,
  output logic signed [31:0]  out_col_1,
  output logic signed [31:0]  out_col_2,
  output logic signed [31:0]  out_col_3,
  output logic                out_last_row
);

  qtrs_pkg::q_stat_t  q_stat;
  qtrs_pkg::item_t    push_data;
  qtrs_pkg::item_t    head;
  logic               push;
  logic               pop;

  qtrs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .in_quat_w  (in_quat_w),
    .in_scale_x (in_scale_x),
    .in_scale_y (in_scale_y),
    .in_scale_z (in_scale_z),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  qtrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  qtrs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_col_0     (out_col_0),
    .out_col_1     (out_col_1),
    .out_col_2     (out_col_2),
    .out_col_3     (out_col_3),
    .out_last_row  (out_last_row)
  );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for quaternion_trs_matrix_core
// Sends transform beats and compares every row beat with an independent
// computation of the scaled, rotated and translated 4x4 matrix. Runs a
// directed set first, then random transforms under changing input gaps and
// output stalls.
// ----------------------------------------------------------------------------
typedef struct packed {
  logic signed [31:0] qx;
  logic signed [31:0] qy;
  logic signed [31:0] qz;
  logic signed [31:0] qw;
  logic signed [31:0] sx;
  logic signed [31:0] sy;
  logic signed [31:0] sz;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
} xform_t;

typedef struct packed {
  logic [1:0]         row;
  logic signed [31:0] c0;
  logic signed [31:0] c1;
  logic signed [31:0] c2;
  logic signed [31:0] c3;
  logic               last;
} matrix_row_t;

class matrix_scoreboard;
  matrix_row_t pending_rows[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Doubled product 2*a*b of two Q2.30 values, floored to Q.30.
  function longint dbl_prod(longint a, longint b);
    return (a * b) >>> 29;
  endfunction

  // Q.30 term times Q16.16 scale, rounded half away from zero, saturated.
  function logic signed [31:0] scale_q16(longint term, longint scl);
    bit [63:0]  mt;
    bit [63:0]  ms;
    bit [127:0] p;
    bit [127:0] q;
    bit         neg;
    mt = (term < 0) ? -term : term;
    ms = (scl < 0) ? -scl : scl;
    p = {64'b0, mt} * {64'b0, ms};
    q = (p >> 30) + p[29];
    neg = (term < 0) != (scl < 0);
    if (neg) begin
      if (q >= 128'h8000_0000) return 32'sh8000_0000;
      return -$signed(q[31:0]);
    end
    if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return q[31:0];
  endfunction

  function matrix_row_t make_row(logic [1:0] idx, logic signed [31:0] c0,
                                 logic signed [31:0] c1, logic signed [31:0] c2,
                                 logic signed [31:0] c3);
    matrix_row_t r;
    r.row = idx;
    r.c0 = c0;
    r.c1 = c1;
    r.c2 = c2;
    r.c3 = c3;
    r.last = (idx == qtrs_pkg::ROW_LAST);
    return r;
  endfunction

  function void note_transform(xform_t t);
    longint x, y, z, w, one;
    longint xx, xy, xz, yy, yz, zz, wx, wy, wz;
    x = t.qx;
    y = t.qy;
    z = t.qz;
    w = t.qw;
    one = qtrs_pkg::ONE_Q30;
    xx = dbl_prod(x, x);
    xy = dbl_prod(x, y);
    xz = dbl_prod(x, z);
    yy = dbl_prod(y, y);
    yz = dbl_prod(y, z);
    zz = dbl_prod(z, z);
    wx = dbl_prod(w, x);
    wy = dbl_prod(w, y);
    wz = dbl_prod(w, z);
    pending_rows.push_back(make_row(qtrs_pkg::ROW_0, scale_q16(one - (yy + zz), t.sx),
                                    scale_q16(xy - wz, t.sy),
                                    scale_q16(xz + wy, t.sz), t.px));
    pending_rows.push_back(make_row(qtrs_pkg::ROW_1, scale_q16(xy + wz, t.sx),
                                    scale_q16(one - (xx + zz), t.sy),
                                    scale_q16(yz - wx, t.sz), t.py));
    pending_rows.push_back(make_row(qtrs_pkg::ROW_2, scale_q16(xz - wy, t.sx),
                                    scale_q16(yz + wx, t.sy),
                                    scale_q16(one - (xx + yy), t.sz), t.pz));
    pending_rows.push_back(make_row(qtrs_pkg::ROW_LAST, qtrs_pkg::ZERO_Q16,
                                    qtrs_pkg::ZERO_Q16, qtrs_pkg::ZERO_Q16,
                                    qtrs_pkg::ONE_Q16));
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_row(matrix_row_t got);
    matrix_row_t want;
    if (pending_rows.size() == 0) begin
      $display("%0t unexpected row beat: expected none, got %h", $time, got);
      errors++;
      return;
    end
    want = pending_rows.pop_front();
    compare_field("row_index", want.row, got.row);
    compare_field("col_0", want.c0, got.c0);
    compare_field("col_1", want.c1, got.c1);
    compare_field("col_2", want.c2, got.c2);
    compare_field("col_3", want.c3, got.c3);
    compare_field("last_row", want.last, got.last);
  endfunction

  function int outstanding();
    return pending_rows.size();
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 120;
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
  localparam logic signed [31:0] Q30_HALF = 32'sh2000_0000;
  localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] SIN45 = 32'sd759250125;
  localparam logic signed [31:0] MAXW = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINW = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_quat_x = '0;
  logic signed [31:0] in_quat_y = '0;
  logic signed [31:0] in_quat_z = '0;
  logic signed [31:0] in_quat_w = '0;
  logic signed [31:0] in_scale_x = '0;
  logic signed [31:0] in_scale_y = '0;
  logic signed [31:0] in_scale_z = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_row_index;
  logic signed [31:0] out_col_0;
  logic signed [31:0] out_col_1;
  logic signed [31:0] out_col_2;
  logic signed [31:0] out_col_3;
  logic out_last_row;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  matrix_scoreboard sb;

  quaternion_trs_matrix_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z),
    .in_quat_w(in_quat_w),
    .in_scale_x(in_scale_x),
    .in_scale_y(in_scale_y),
    .in_scale_z(in_scale_z),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row_index(out_row_index),
    .out_col_0(out_col_0),
    .out_col_1(out_col_1),
    .out_col_2(out_col_2),
    .out_col_3(out_col_3),
    .out_last_row(out_last_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_transform({in_quat_x, in_quat_y, in_quat_z, in_quat_w, in_scale_x,
                           in_scale_y, in_scale_z, in_pos_x, in_pos_y, in_pos_z});
      if (out_valid && !out_stall)
        sb.check_row({out_row_index, out_col_0, out_col_1, out_col_2, out_col_3,
                      out_last_row});
    end
  end

  function automatic xform_t mk(logic signed [31:0] qx, logic signed [31:0] qy,
                                logic signed [31:0] qz, logic signed [31:0] qw,
                                logic signed [31:0] sx, logic signed [31:0] sy,
                                logic signed [31:0] sz, logic signed [31:0] px,
                                logic signed [31:0] py, logic signed [31:0] pz);
    return {qx, qy, qz, qw, sx, sy, sz, px, py, pz};
  endfunction

  function automatic logic [31:0] corner_word();
    case ($urandom_range(3))
      0: return MAXW;
      1: return MINW;
      2: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // Random rotation of unit length, built in floating point and quantized.
  function automatic xform_t with_unit_quat(xform_t t);
    real a, b, c, d, n;
    a = real'(int'($urandom_range(2000000)) - 1000000);
    b = real'(int'($urandom_range(2000000)) - 1000000);
    c = real'(int'($urandom_range(2000000)) - 1000000);
    d = real'(int'($urandom_range(2000000)) - 1000000);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      a = 0.0;
      b = 0.0;
      c = 0.0;
      d = 1.0;
      n = 1.0;
    end
    t.qx = $rtoi(a / n * 1073741824.0);
    t.qy = $rtoi(b / n * 1073741824.0);
    t.qz = $rtoi(c / n * 1073741824.0);
    t.qw = $rtoi(d / n * 1073741824.0);
    return t;
  endfunction

  function automatic xform_t rand_xform();
    xform_t t;
    int pick;
    pick = $urandom_range(99);
    t = {$urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom};
    if (pick < 55) begin
      // Realistic transform: unit rotation and scales within +/-8.0.
      t = with_unit_quat(t);
      t.sx = int'($urandom_range(1048576)) - 524288;
      t.sy = int'($urandom_range(1048576)) - 524288;
      t.sz = int'($urandom_range(1048576)) - 524288;
    end else if (pick < 85 && pick >= 70) begin
      t = with_unit_quat(t);
    end else if (pick >= 85) begin
      t = {corner_word(), corner_word(), corner_word(), corner_word(), corner_word(),
           corner_word(), corner_word(), corner_word(), corner_word(), corner_word()};
    end
    return t;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_xform(input xform_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_quat_x <= t.qx;
    in_quat_y <= t.qy;
    in_quat_z <= t.qz;
    in_quat_w <= t.qw;
    in_scale_x <= t.sx;
    in_scale_y <= t.sy;
    in_scale_z <= t.sz;
    in_pos_x <= t.px;
    in_pos_y <= t.py;
    in_pos_z <= t.pz;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_xform(mk(0, 0, 0, Q30_ONE, Q16_ONE, Q16_ONE, Q16_ONE, 0, 0, 0));
    send_xform(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_xform(mk(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW));
    send_xform(mk(MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW));
    send_xform(mk(MAXW, MAXW, MAXW, MAXW, MINW, MINW, MINW, MAXW, MAXW, MAXW));
    send_xform(mk(MINW, MINW, MINW, MINW, MAXW, MAXW, MAXW, MINW, MINW, MINW));
    send_xform(mk(SIN45, 0, 0, SIN45, Q16_ONE, Q16_ONE, Q16_ONE,
                  Q16_ONE, 2 * Q16_ONE, -3 * Q16_ONE));
    send_xform(mk(0, SIN45, 0, SIN45, 2 * Q16_ONE, Q16_ONE, -Q16_ONE, 0, MAXW, MINW));
    send_xform(mk(0, 0, -SIN45, SIN45, Q16_ONE, 3 * Q16_ONE, Q16_ONE, MINW, 0, MAXW));
    // Mirrored scales on a half turn, then two collapsed axes.
    send_xform(mk(Q30_ONE, 0, 0, 0, -Q16_ONE, -2 * Q16_ONE, 0, 5, -5, 1));
    send_xform(mk(SIN45, -SIN45, 0, 0, 0, 0, Q16_ONE, 0, 0, 0));
    // Diagonal terms of exactly 0.5 with unit-lsb scales hit the rounding tie.
    send_xform(mk(0, Q30_HALF, 0, 0, 1, -1, 1, 0, 0, 0));
    send_xform(mk(Q30_HALF, 0, Q30_HALF, 0, -1, 1, -1, 0, 0, 0));
    // Quaternions far from unit length, or the most negative scales, drive the columns to their limits.
    send_xform(mk(MAXW, 0, 0, MAXW, 32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000,
                  1, 2, 3));
    send_xform(mk(0, 0, 0, -Q30_ONE, MINW, MINW, MINW, 0, 0, 0));
    send_xform(mk(MINW, MINW, MAXW, 0, Q16_ONE, Q16_ONE, Q16_ONE, 0, 0, 0));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 65;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 65;
        end
        default: begin
          idle_pct = 13;
          stall_pct = 13;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_xform(rand_xform());
      // Hold the sender off until every row beat of this phase is back.
      drain();
    end

    stall_pct = 0;
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/qtrs_pkg.sv
rtl/qtrs_front.sv
rtl/qtrs_queue.sv
rtl/qtrs_back.sv
rtl/quaternion_trs_matrix_core.sv
test/tb.sv
